// ===== rtl/core/bnaf_pkg.sv =====
package bnaf_pkg;

    // Fixed field widths
    localparam int STATE_W  = 8;
    localparam int ROW_W    = 8;
    localparam int MATRIX_W = 64;
    localparam int COUNT_W  = 9;
    localparam int MAP_DEPTH = 256;

    // Default sizing
    localparam int NODES_DEF   = 8;
    localparam int HISTORY_DEF = 256;

    // Node operator codes, picked by node index mod 4
    localparam logic [1:0] OP_OR       = 2'd0;
    localparam logic [1:0] OP_AND      = 2'd1;
    localparam logic [1:0] OP_ANY_ZERO = 2'd2;
    localparam logic [1:0] OP_ALL_ZERO = 2'd3;

    // Controls from the sequencer to the history chain
    typedef struct packed {
        logic load;     // restart the chain with the start state in the first cell
        logic push;     // shift a new state into the first cell
    } chain_ctrl_t;

    function automatic logic [1:0] node_op(input int idx);
        return 2'(idx & 3);
    endfunction

endpackage

// ===== rtl/core/bnaf_net.sv =====
module bnaf_net #(
    parameter int NODES = bnaf_pkg::NODES_DEF
) (
    input  logic [bnaf_pkg::MATRIX_W-1:0] connection_matrix,
    input  logic [bnaf_pkg::STATE_W-1:0]  state,
    output logic [bnaf_pkg::STATE_W-1:0]  next_state
);

    localparam logic [bnaf_pkg::STATE_W-1:0] NODE_MASK =
        bnaf_pkg::STATE_W'((1 << NODES) - 1);

    genvar i;
    generate
        for (i = 0; i < bnaf_pkg::STATE_W; i++) begin : g_node
            if (i < NODES) begin : g_live
                logic [bnaf_pkg::STATE_W-1:0] row;
                logic [bnaf_pkg::STATE_W-1:0] ones;
                logic [bnaf_pkg::STATE_W-1:0] zeros;
                logic                         bit_val;

                // Select the inputs this node reads
                assign row   = connection_matrix[bnaf_pkg::ROW_W*i +: bnaf_pkg::ROW_W]
                               & NODE_MASK;
                assign ones  = row & state;
                assign zeros = row & ~state & NODE_MASK;

                // Apply the operator of this node; no inputs gives zero
                always_comb
                begin
                    unique case (bnaf_pkg::node_op(i))
                        bnaf_pkg::OP_OR:       bit_val = |ones;
                        bnaf_pkg::OP_AND:      bit_val = (|row) && !(|zeros);
                        bnaf_pkg::OP_ANY_ZERO: bit_val = |zeros;
                        bnaf_pkg::OP_ALL_ZERO: bit_val = (|row) && !(|ones);
                        default:               bit_val = 1'b0;
                    endcase
                end

                assign next_state[i] = bit_val;
            end else begin : g_dead
                assign next_state[i] = 1'b0;
            end
        end
    endgenerate

endmodule

// ===== rtl/core/bnaf_cell.sv =====
module bnaf_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic                         clear,
    input  logic [bnaf_pkg::STATE_W-1:0] data_in,
    input  logic                         occ_in,
    input  logic [bnaf_pkg::STATE_W-1:0] probe,
    output logic [bnaf_pkg::STATE_W-1:0] data_out,
    output logic                         occ_out,
    output logic                         match
);

    logic [bnaf_pkg::STATE_W-1:0] data_reg;
    logic                         occ_reg;

    // Take the neighbor's state when the chain advances
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_in;
        end
    end

    // Track whether this cell holds a state of the current run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (clear)
        begin
            occ_reg <= 1'b0;
        end
        else if (shift)
        begin
            occ_reg <= occ_in;
        end
    end

    // Compare the held state with the new one
    assign match    = occ_reg && (data_reg == probe);
    assign data_out = data_reg;
    assign occ_out  = occ_reg;

endmodule

// ===== rtl/core/bnaf_chain.sv =====
module bnaf_chain #(
    parameter int HISTORY_DEPTH = bnaf_pkg::HISTORY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bnaf_pkg::chain_ctrl_t        ctrl,
    input  logic [bnaf_pkg::STATE_W-1:0] value,
    input  logic [bnaf_pkg::STATE_W-1:0] probe,
    output logic                         hit
);

    logic [bnaf_pkg::STATE_W-1:0] data_w [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]     occ_w;
    logic [HISTORY_DEPTH-1:0]     match_w;

    genvar k;
    generate
        for (k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                // First cell takes the new state on load or push
                bnaf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (ctrl.push || ctrl.load),
                    .clear    (1'b0),
                    .data_in  (value),
                    .occ_in   (1'b1),
                    .probe    (probe),
                    .data_out (data_w[k]),
                    .occ_out  (occ_w[k]),
                    .match    (match_w[k])
                );
            end else begin : g_body
                // Later cells take the neighbor's state; load empties them
                bnaf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (ctrl.push),
                    .clear    (ctrl.load),
                    .data_in  (data_w[k-1]),
                    .occ_in   (occ_w[k-1]),
                    .probe    (probe),
                    .data_out (data_w[k]),
                    .occ_out  (occ_w[k]),
                    .match    (match_w[k])
                );
            end
        end
    endgenerate

    // Flag a repeat anywhere in the history
    assign hit = |match_w;

endmodule

// ===== rtl/core/boolean_network_attractor_finder.sv =====
// Boolean network attractor finder. Write the 64-bit connection matrix (row i
// in bits 8i..8i+7, bit j set when node i reads node j) while the block is
// idle, then send start states. For each start state the network steps once
// per cycle through the network update logic while a chain of HISTORY_DEPTH
// cells holds the trajectory and flags the first repeat; the same update
// logic then walks the attractor once more to measure its length and, for a
// new attractor, mark its states in the attractor map. A run that fills the
// history without a repeat skips that walk. The block takes one start state
// at a time and accepts no new one until its run is done. A finished result
// sits in an output register, and the next start state is taken while it
// waits.
module boolean_network_attractor_finder #(
    parameter int NODES         = bnaf_pkg::NODES_DEF,
    parameter int HISTORY_DEPTH = bnaf_pkg::HISTORY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bnaf_pkg::MATRIX_W-1:0] connection_matrix,
    // start state request
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bnaf_pkg::STATE_W-1:0]  start_state,
    // result
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bnaf_pkg::COUNT_W-1:0]  cycle_length,
    output logic [bnaf_pkg::STATE_W-1:0]  transient_length,
    output logic [bnaf_pkg::STATE_W-1:0]  entry_state,
    output logic                          is_new,
    output logic [bnaf_pkg::COUNT_W-1:0]  distinct_count
);

    localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(HISTORY_DEPTH);
    localparam logic [bnaf_pkg::STATE_W-1:0] NODE_MASK =
        bnaf_pkg::STATE_W'((1 << NODES) - 1);
    localparam logic [bnaf_pkg::STATE_W-1:0] FULL_TRANSIENT =
        bnaf_pkg::STATE_W'(HISTORY_DEPTH - 1);
    localparam logic [bnaf_pkg::COUNT_W-1:0] TOTAL_MAX =
        bnaf_pkg::COUNT_W'(bnaf_pkg::MAP_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CYCLE,
        S_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [bnaf_pkg::MATRIX_W-1:0]   matrix_reg, matrix_next;
    logic [bnaf_pkg::STATE_W-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [bnaf_pkg::STATE_W-1:0]    entry_reg, entry_next;
    logic [bnaf_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    logic                            new_reg, new_next;
    logic                            full_reg, full_next;
    logic [bnaf_pkg::COUNT_W-1:0]    total_reg, total_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bnaf_pkg::COUNT_W-1:0]    cycle_length_reg, cycle_length_next;
    logic [bnaf_pkg::STATE_W-1:0]    transient_length_reg, transient_length_next;
    logic [bnaf_pkg::STATE_W-1:0]    entry_state_reg, entry_state_next;
    logic                            is_new_reg, is_new_next;
    logic [bnaf_pkg::COUNT_W-1:0]    distinct_count_reg, distinct_count_next;
    logic [bnaf_pkg::MAP_DEPTH-1:0]  map_reg;

    logic [bnaf_pkg::STATE_W-1:0]    next_v;
    logic [bnaf_pkg::STATE_W-1:0]    start_masked;
    logic [bnaf_pkg::STATE_W-1:0]    chain_value;
    bnaf_pkg::chain_ctrl_t           chain_ctrl;
    logic                            hit;
    logic                            in_fire;
    logic                            out_free;

    // Network update on the current state
    bnaf_net #(
        .NODES (NODES)
    ) u_net (
        .connection_matrix (matrix_reg),
        .state             (cur_reg),
        .next_state        (next_v)
    );

    // Trajectory history
    bnaf_chain #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (chain_ctrl),
        .value (chain_value),
        .probe (next_v),
        .hit   (hit)
    );

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign start_masked = start_state & NODE_MASK;

    // Drive the history chain
    always_comb
    begin
        chain_ctrl.load = in_fire;
        chain_ctrl.push = (state_reg == S_WALK) && !hit && (len_reg != LEN_FULL);
        chain_value     = in_fire ? start_masked : next_v;
    end

    // Sequence one run
    always_comb
    begin
        state_next            = state_reg;
        matrix_next           = matrix_reg;
        cur_next              = cur_reg;
        len_next              = len_reg;
        entry_next            = entry_reg;
        cnt_next              = cnt_reg;
        new_next              = new_reg;
        full_next             = full_reg;
        total_next            = total_reg;
        out_valid_next        = out_valid_reg && !out_ready;
        cycle_length_next     = cycle_length_reg;
        transient_length_next = transient_length_reg;
        entry_state_next      = entry_state_reg;
        is_new_next           = is_new_reg;
        distinct_count_next   = distinct_count_reg;

        if (cfg_valid)
        begin
            matrix_next = connection_matrix;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next   = start_masked;
                    len_next   = LEN_W'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    // Repeat found: next_v is the entry state
                    entry_next = next_v;
                    cur_next   = next_v;
                    cnt_next   = '0;
                    full_next  = 1'b0;
                    new_next   = !map_reg[next_v];
                    state_next = S_CYCLE;
                end
                else if (len_reg == LEN_FULL)
                begin
                    // History full with no repeat
                    entry_next = next_v;
                    cnt_next   = '0;
                    full_next  = 1'b1;
                    new_next   = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    cur_next = next_v;
                    len_next = len_reg + LEN_W'(1);
                end
            end
            S_CYCLE:
            begin
                // Count a new attractor on the first step of the walk
                if (new_reg && (cnt_reg == '0) && (total_reg != TOTAL_MAX))
                begin
                    total_next = total_reg + bnaf_pkg::COUNT_W'(1);
                end
                // Walk the attractor once, counting its states
                cnt_next = cnt_reg + bnaf_pkg::COUNT_W'(1);
                cur_next = next_v;
                if (next_v == entry_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    cycle_length_next   = cnt_reg;
                    entry_state_next    = entry_reg;
                    is_new_next         = new_reg;
                    distinct_count_next = total_reg;
                    if (full_reg)
                    begin
                        transient_length_next = FULL_TRANSIENT;
                    end
                    else
                    begin
                        transient_length_next =
                            bnaf_pkg::STATE_W'(bnaf_pkg::COUNT_W'(len_reg) - cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, working registers and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            matrix_reg           <= '0;
            cur_reg              <= '0;
            len_reg              <= '0;
            entry_reg            <= '0;
            cnt_reg              <= '0;
            new_reg              <= 1'b0;
            full_reg             <= 1'b0;
            total_reg            <= '0;
            out_valid_reg        <= 1'b0;
            cycle_length_reg     <= '0;
            transient_length_reg <= '0;
            entry_state_reg      <= '0;
            is_new_reg           <= 1'b0;
            distinct_count_reg   <= '0;
        end
        else
        begin
            state_reg            <= state_next;
            matrix_reg           <= matrix_next;
            cur_reg              <= cur_next;
            len_reg              <= len_next;
            entry_reg            <= entry_next;
            cnt_reg              <= cnt_next;
            new_reg              <= new_next;
            full_reg             <= full_next;
            total_reg            <= total_next;
            out_valid_reg        <= out_valid_next;
            cycle_length_reg     <= cycle_length_next;
            transient_length_reg <= transient_length_next;
            entry_state_reg      <= entry_state_next;
            is_new_reg           <= is_new_next;
            distinct_count_reg   <= distinct_count_next;
        end
    end

    // Mark each state of a new attractor while walking it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else if ((state_reg == S_CYCLE) && new_reg)
        begin
            map_reg[cur_reg] <= 1'b1;
        end
    end

    assign out_valid        = out_valid_reg;
    assign cycle_length     = cycle_length_reg;
    assign transient_length = transient_length_reg;
    assign entry_state      = entry_state_reg;
    assign is_new           = is_new_reg;
    assign distinct_count   = distinct_count_reg;

endmodule

// ===== rtl/core/bnaf_checker.sv =====
module bnaf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bnaf_pkg::COUNT_W-1:0]  cycle_length,
    input logic [bnaf_pkg::STATE_W-1:0]  transient_length,
    input logic [bnaf_pkg::STATE_W-1:0]  entry_state,
    input logic                          is_new,
    input logic [bnaf_pkg::COUNT_W-1:0]  distinct_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cycle_length)
            && $stable(transient_length) && $stable(entry_state)
            && $stable(is_new) && $stable(distinct_count))
        else $error("stalled result changed");

    // A taken request leaves the block busy for the run
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a run is in progress");

    // A new attractor has a real cycle and is counted
    a_new_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> (cycle_length != '0) && (distinct_count != '0))
        else $error("new attractor without cycle or count");

    // A run that ran out of history is never new
    a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cycle_length == '0) |-> !is_new)
        else $error("history-full result flagged as new");

endmodule

bind boolean_network_attractor_finder bnaf_checker u_bnaf_checker (.*);
